// ===== rtl/mssle_pkg.sv =====
// package: shared constants, status codes and saturation helper for the slope estimator
`default_nettype none

package mssle_pkg;

  // default width of the point counter
  localparam int unsigned INDEX_BITS = 16;

  // shared divider geometry
  localparam int unsigned DVD_W = 64;
  localparam int unsigned DVS_W = 33;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_XORDER = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;

  // saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -65'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mssle_if.sv =====
// interfaces: point request channel and derivative result channel
`default_nettype none

interface mssle_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] knot_x;
  logic signed [31:0] knot_y;
  logic               final_point;

  modport source(output valid, output knot_x, output knot_y, output final_point, input ready);
  modport sink(input valid, input knot_x, input knot_y, input final_point, output ready);
endinterface

interface mssle_rsp_if;
  logic               valid;
  logic               ready;
  logic        [15:0] point_index;
  logic signed [31:0] slope_estimate;
  logic        [1:0]  status_code;
  logic               run_end;

  modport source(output valid, output point_index, output slope_estimate, output status_code,
                 output run_end, input ready);
  modport sink(input valid, input point_index, input slope_estimate, input status_code,
               input run_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/mssle_div.sv =====
// shared radix-2 restoring divider, unsigned, one quotient bit per cycle
`default_nettype none

module mssle_div #(
  parameter int unsigned DvdW = mssle_pkg::DVD_W,
  parameter int unsigned DvsW = mssle_pkg::DVS_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dvd_i,
  input  wire logic [DvsW-1:0] dvs_i,
  output logic                 done_o,
  output logic [DvdW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvdW-1:0] quo_q;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            qbit;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[DvdW-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= dvs_i;
      quo_q <= dvd_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_q <= {quo_q[DvdW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/monotone_spline_slope_estimator_core.sv =====
// Shape-preserving derivative estimator: sequencer, shared multiplier and shared divider.
// Each point runs a slope division, then per derived estimate a shrink, one multiply (two
// for an interior estimate), a division and a clamp; up to 4 divisions per point.
// Throughput: one point at a time; ready is low until all its results are taken.
// Most of the time is spent in the 64-step radix-2 divider.
// Reset: asynchronous active low, clears the counter, previous point and failure flag.
`default_nettype none

module monotone_spline_slope_estimator_core #(
  parameter int unsigned IndexBits = mssle_pkg::INDEX_BITS
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  mssle_req_if.sink    req_i,
  mssle_rsp_if.source  rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SDIV, S_SETUP, S_SHRINK, S_MUL1, S_MUL2, S_MACC, S_DIVGO,
    S_ODIV, S_CLAMP, S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    NX_IDLE, NX_RESET, NX_PAIR, NX_MID, NX_TAIL
  } next_e;

  typedef enum logic [1:0] {
    OP_END0, OP_MID, OP_END1
  } op_e;

  localparam int unsigned DvdW = mssle_pkg::DVD_W;
  localparam int unsigned DvsW = mssle_pkg::DVS_W;

  state_e state_q;
  next_e  nxt_q;
  op_e    op_q;

  // current point
  logic signed [31:0]   x_q, y_q;
  logic                 fin_q;
  logic [IndexBits-1:0] idx_q;
  logic [IndexBits-1:0] cnt_q;
  logic [32:0]          dx_q;
  logic signed [31:0]   s_q;

  // previous point
  logic signed [31:0]   last_x_q, last_y_q, last_s_q;
  logic [32:0]          last_dx_q;
  logic                 failed_q;

  // operation registers
  logic                 mid_q;
  logic [32:0]          wa_q, wb_q;
  logic signed [31:0]   sa_q, sb_q;
  logic signed [63:0]   prod_q, acc_q;
  logic                 neg_q;

  // result register
  logic [IndexBits-1:0] out_idx_q;
  logic signed [31:0]   out_slope_q;
  logic [1:0]           out_st_q;
  logic                 out_end_q;

  // point differences
  logic signed [32:0] dxs, dys;
  logic [32:0]        dy_mag;
  logic               dx_pos;
  always_comb begin
    dxs    = {x_q[31], x_q} - {last_x_q[31], last_x_q};
    dys    = {y_q[31], y_q} - {last_y_q[31], last_y_q};
    dy_mag = dys[32] ? 33'(-dys) : 33'(dys);
    dx_pos = !dxs[32] && (dxs != '0);
  end

  // shared multiplier
  logic [29:0]        mul_a;
  logic signed [32:0] mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    if (state_q == S_MUL2) begin
      mul_a = wb_q[29:0];
      mul_b = {sa_q[31], sa_q};
    end else if (mid_q) begin
      mul_a = wa_q[29:0];
      mul_b = {sb_q[31], sb_q};
    end else begin
      mul_a = wa_q[29:0];
      mul_b = {sa_q[31], sa_q} - {sb_q[31], sb_q};
    end
    mul_p = $signed({1'b0, mul_a}) * mul_b;
  end

  // divider operand selection
  logic            div_start;
  logic [DvdW-1:0] div_dvd;
  logic [DvsW-1:0] div_dvs;
  logic            div_done;
  logic [DvdW-1:0] div_quo;
  logic [30:0]     wsum;
  always_comb begin
    wsum = {1'b0, wa_q[29:0]} + {1'b0, wb_q[29:0]};
    if (state_q == S_CHECK) begin
      div_start = !failed_q && (idx_q != '0) && dx_pos;
      div_dvd   = {15'd0, dy_mag, 16'd0};
      div_dvs   = DvsW'(dxs);
    end else begin
      div_start = (state_q == S_DIVGO);
      div_dvd   = acc_q[63] ? DvdW'(-acc_q) : DvdW'(acc_q);
      div_dvs   = {2'b00, wsum};
    end
  end

  mssle_div #(
    .DvdW(DvdW),
    .DvsW(DvsW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dvd_i  (div_dvd),
    .dvs_i  (div_dvs),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // signed quotient and saturated slope
  logic signed [64:0] qs;
  logic signed [31:0] slope_sat;
  always_comb begin
    qs        = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    slope_sat = mssle_pkg::sat32(qs);
  end

  // clamp of the estimate
  logic signed [35:0] t36, lim, sa36, sb36, ap, an;
  logic               pos;
  logic signed [35:0] ct;
  always_comb begin
    sa36 = 36'(sa_q);
    sb36 = 36'(sb_q);
    ap   = sa_q[31] ? -sa36 : sa36;
    an   = sb_q[31] ? -sb36 : sb36;
    if (mid_q) begin
      t36 = qs[35:0];
      pos = (ap > an) ? !sa_q[31] : !sb_q[31];
      lim = (ap < an) ? (ap <<< 1) + ap : (an <<< 1) + an;
      if (pos) begin
        ct = (t36 < 0) ? 36'sd0 : ((t36 > lim) ? lim : t36);
      end else begin
        ct = (t36 > 0) ? 36'sd0 : ((t36 < -lim) ? -lim : t36);
      end
    end else begin
      t36 = sa36 + qs[35:0];
      pos = !sa_q[31];
      lim = (sa36 <<< 1) + sa36;
      if (pos) begin
        ct = (t36 < 0) ? 36'sd0 : ((t36 > lim) ? lim : t36);
      end else begin
        ct = (t36 > 0) ? 36'sd0 : ((t36 < lim) ? lim : t36);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nxt_q     <= NX_IDLE;
      op_q      <= OP_END0;
      cnt_q     <= '0;
      last_x_q  <= '0;
      last_y_q  <= '0;
      last_dx_q <= '0;
      last_s_q  <= '0;
      failed_q  <= 1'b0;
      mid_q     <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            x_q   <= req_i.knot_x;
            y_q   <= req_i.knot_y;
            fin_q <= req_i.final_point;
            idx_q <= cnt_q;
            if (cnt_q != '1) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          out_slope_q <= '0;
          out_idx_q   <= idx_q;
          if (failed_q) begin
            out_st_q  <= mssle_pkg::ST_XORDER;
            out_end_q <= 1'b1;
            nxt_q     <= NX_RESET;
            state_q   <= fin_q ? S_EMIT : S_IDLE;
          end else if (idx_q == '0) begin
            last_x_q  <= x_q;
            last_y_q  <= y_q;
            out_st_q  <= mssle_pkg::ST_SHORT;
            out_end_q <= 1'b1;
            nxt_q     <= NX_RESET;
            state_q   <= fin_q ? S_EMIT : S_IDLE;
          end else if (!dx_pos) begin
            out_st_q  <= mssle_pkg::ST_XORDER;
            out_end_q <= fin_q;
            nxt_q     <= fin_q ? NX_RESET : NX_IDLE;
            failed_q  <= !fin_q;
            state_q   <= S_EMIT;
          end else begin
            dx_q    <= dxs;
            neg_q   <= dys[32];
            state_q <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            s_q <= slope_sat;
            if (idx_q == IndexBits'(1)) begin
              if (fin_q) begin
                out_idx_q   <= '0;
                out_slope_q <= slope_sat;
                out_st_q    <= mssle_pkg::ST_OK;
                out_end_q   <= 1'b0;
                nxt_q       <= NX_PAIR;
                state_q     <= S_EMIT;
              end else begin
                last_x_q  <= x_q;
                last_y_q  <= y_q;
                last_dx_q <= dx_q;
                last_s_q  <= slope_sat;
                state_q   <= S_IDLE;
              end
            end else begin
              op_q    <= (idx_q == IndexBits'(2)) ? OP_END0 : OP_MID;
              state_q <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          out_st_q <= mssle_pkg::ST_OK;
          case (op_q)
            OP_END0: begin
              wa_q <= last_dx_q; wb_q <= dx_q; sa_q <= last_s_q; sb_q <= s_q;
              mid_q <= 1'b0; out_idx_q <= '0; out_end_q <= 1'b0; nxt_q <= NX_MID;
            end
            OP_MID: begin
              wa_q <= last_dx_q; wb_q <= dx_q; sa_q <= last_s_q; sb_q <= s_q;
              mid_q <= 1'b1; out_idx_q <= idx_q - 1'b1; out_end_q <= 1'b0; nxt_q <= NX_TAIL;
            end
            default: begin
              wa_q <= dx_q; wb_q <= last_dx_q; sa_q <= s_q; sb_q <= last_s_q;
              mid_q <= 1'b0; out_idx_q <= idx_q; out_end_q <= 1'b1; nxt_q <= NX_RESET;
            end
          endcase
          state_q <= S_SHRINK;
        end
        S_SHRINK: begin
          // scale both weights below 2^30
          if ((wa_q[32:30] | wb_q[32:30]) != 3'd0) begin
            wa_q <= wa_q >> 1;
            wb_q <= wb_q >> 1;
          end else begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_q  <= mul_p;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          acc_q <= prod_q;
          if (mid_q) begin
            prod_q  <= mul_p;
            state_q <= S_MACC;
          end else begin
            state_q <= S_DIVGO;
          end
        end
        S_MACC: begin
          acc_q   <= acc_q + prod_q;
          state_q <= S_DIVGO;
        end
        S_DIVGO: begin
          neg_q   <= acc_q[63];
          state_q <= S_ODIV;
        end
        S_ODIV: begin
          if (div_done) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          out_slope_q <= mssle_pkg::sat32(65'(ct));
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_o.ready) begin
            case (nxt_q)
              NX_RESET: begin
                cnt_q     <= '0;
                last_x_q  <= '0;
                last_y_q  <= '0;
                last_dx_q <= '0;
                last_s_q  <= '0;
                failed_q  <= 1'b0;
                state_q   <= S_IDLE;
              end
              NX_PAIR: begin
                out_idx_q <= IndexBits'(1);
                out_end_q <= 1'b1;
                nxt_q     <= NX_RESET;
              end
              NX_MID: begin
                op_q    <= OP_MID;
                state_q <= S_SETUP;
              end
              NX_TAIL: begin
                if (fin_q) begin
                  op_q    <= OP_END1;
                  state_q <= S_SETUP;
                end else begin
                  last_x_q  <= x_q;
                  last_y_q  <= y_q;
                  last_dx_q <= dx_q;
                  last_s_q  <= s_q;
                  state_q   <= S_IDLE;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // index masked to the 16-bit result field
  logic [15:0] idx16;
  if (IndexBits >= 16) begin : g_idx_wide
    assign idx16 = out_idx_q[15:0];
  end else begin : g_idx_narrow
    assign idx16 = {{(16 - IndexBits){1'b0}}, out_idx_q};
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = (state_q == S_EMIT);
  assign rsp_o.point_index    = idx16;
  assign rsp_o.slope_estimate = out_slope_q;
  assign rsp_o.status_code    = out_st_q;
  assign rsp_o.run_end        = out_end_q;

endmodule

`default_nettype wire

// ===== bench/monotone_spline_slope_estimator_core_tb.sv =====
// testbench: directed and random point streams checked against a derivative predictor
`default_nettype none

module monotone_spline_slope_estimator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [15:0]        point_index;
    logic signed [31:0] slope_estimate;
    logic [1:0]         status_code;
    logic               run_end;
  } deriv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  bit rsp_stall_long = 1'b0;

  mssle_req_if req_if ();
  mssle_rsp_if rsp_if ();

  monotone_spline_slope_estimator_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  longint unsigned pt_count;
  longint          prev_x;
  longint          prev_y;
  longint          prev_dx;
  longint          prev_slope;
  bit              set_failed;
  deriv_t          deriv_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void scale_weights(inout longint a, inout longint b);
    while ((a | b) >= (64'sd1 << 30)) begin
      a = a >>> 1;
      b = b >>> 1;
    end
  endfunction

  function automatic longint labs(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // extrapolated end derivative, clamped by sign of the end slope
  function automatic longint end_deriv(longint s_near, longint dx_near, longint s_far,
                                       longint dx_far);
    longint a, b, t, lim;
    a = dx_near;
    b = dx_far;
    scale_weights(a, b);
    t = s_near + (a * (s_near - s_far)) / (a + b);
    lim = 3 * s_near;
    if (s_near >= 0) begin
      if (t < 0) t = 0;
      if (t > lim) t = lim;
    end else begin
      if (t > 0) t = 0;
      if (t < lim) t = lim;
    end
    return clip32(t);
  endfunction

  // weighted interior derivative
  function automatic longint mid_deriv(longint dx_p, longint s_p, longint dx_n, longint s_n);
    longint a, b, t, ap, an, lim;
    bit pos;
    a = dx_p;
    b = dx_n;
    scale_weights(a, b);
    t = (a * s_n + b * s_p) / (a + b);
    ap = labs(s_p);
    an = labs(s_n);
    pos = (s_n >= 0);
    if (ap > an) pos = (s_p >= 0);
    lim = 3 * ((ap < an) ? ap : an);
    if (pos) begin
      if (t < 0) t = 0;
      if (t > lim) t = lim;
    end else begin
      if (t > 0) t = 0;
      if (t < -lim) t = -lim;
    end
    return clip32(t);
  endfunction

  function automatic void clear_set();
    pt_count = 0;
    prev_x = 0;
    prev_y = 0;
    prev_dx = 0;
    prev_slope = 0;
    set_failed = 1'b0;
  endfunction

  function automatic void push_deriv(longint unsigned idx, longint slope, logic [1:0] st,
                                     bit fin);
    deriv_t d;
    d.point_index = idx[15:0];
    d.slope_estimate = slope[31:0];
    d.status_code = st;
    d.run_end = fin;
    deriv_q.push_back(d);
  endfunction

  // expected derivatives for one accepted point
  function automatic void predict_point(logic signed [31:0] kx, logic signed [31:0] ky, bit fin);
    longint x, y, dxs, s;
    longint unsigned idx;
    x = kx;
    y = ky;
    idx = pt_count;
    if (pt_count < 65535) pt_count++;
    if (set_failed) begin
      if (fin) begin
        push_deriv(idx, 0, mssle_pkg::ST_XORDER, 1'b1);
        clear_set();
      end
      return;
    end
    if (idx == 0) begin
      prev_x = x;
      prev_y = y;
      if (fin) begin
        push_deriv(0, 0, mssle_pkg::ST_SHORT, 1'b1);
        clear_set();
      end
      return;
    end
    dxs = x - prev_x;
    if (dxs <= 0) begin
      push_deriv(idx, 0, mssle_pkg::ST_XORDER, fin);
      if (fin) clear_set();
      else set_failed = 1'b1;
      return;
    end
    s = clip32(((y - prev_y) * 65536) / dxs);
    if (idx == 1) begin
      if (fin) begin
        push_deriv(0, s, mssle_pkg::ST_OK, 1'b0);
        push_deriv(1, s, mssle_pkg::ST_OK, 1'b1);
        clear_set();
        return;
      end
    end else begin
      if (idx == 2) begin
        push_deriv(0, end_deriv(prev_slope, prev_dx, s, dxs), mssle_pkg::ST_OK, 1'b0);
      end
      push_deriv(idx - 1, mid_deriv(prev_dx, prev_slope, dxs, s), mssle_pkg::ST_OK, 1'b0);
      if (fin) begin
        push_deriv(idx, end_deriv(s, dxs, prev_slope, prev_dx), mssle_pkg::ST_OK, 1'b1);
        clear_set();
        return;
      end
    end
    prev_x = x;
    prev_y = y;
    prev_dx = dxs;
    prev_slope = s;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result ready with random stalls
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!rsp_stall_long && $urandom_range(0, 3) == 0) rsp_if.ready <= 1'b0;
      else if (rsp_stall_long && $urandom_range(0, 19) != 0) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    deriv_t exp_d;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (deriv_q.size() == 0) begin
        $error("unexpected result index %0d", rsp_if.point_index);
        fail_cnt++;
      end else begin
        exp_d = deriv_q.pop_front();
        if (rsp_if.point_index !== exp_d.point_index) begin
          $error("point_index exp %0d got %0d", exp_d.point_index, rsp_if.point_index);
          fail_cnt++;
        end
        if (rsp_if.slope_estimate !== exp_d.slope_estimate) begin
          $error("slope_estimate exp %0d got %0d", exp_d.slope_estimate,
                 rsp_if.slope_estimate);
          fail_cnt++;
        end
        if (rsp_if.status_code !== exp_d.status_code) begin
          $error("status_code exp %0d got %0d", exp_d.status_code, rsp_if.status_code);
          fail_cnt++;
        end
        if (rsp_if.run_end !== exp_d.run_end) begin
          $error("run_end exp %0d got %0d", exp_d.run_end, rsp_if.run_end);
          fail_cnt++;
        end
      end
    end
  end

  // send one point request, with a random gap before it
  task automatic send_point(logic signed [31:0] kx, logic signed [31:0] ky, bit fin);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.knot_x <= kx;
    req_if.knot_y <= ky;
    req_if.final_point <= fin;
    do @(posedge clk_i); while (!req_if.ready);
    predict_point(kx, ky, fin);
  endtask

  task automatic test_short_sets();
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_point(32'sd0, 32'sd100, 1'b0);
    send_point(32'sd1, 32'sh8000_0000, 1'b1);
  endtask

  task automatic test_extremes();
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh8000_0001, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh7FFF_FFFE, 32'sh8000_0000, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh0001_0000, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sh0001_0000, 32'sh0002_0000, 1'b0);
    send_point(32'sh0002_0000, 32'sh0001_0000, 1'b0);
    send_point(32'sh0003_0000, 32'sh0001_0000, 1'b1);
  endtask

  task automatic test_x_order();
    send_point(32'sd10, 32'sd5, 1'b0);
    send_point(32'sd10, 32'sd6, 1'b0);
    send_point(32'sd20, 32'sd7, 1'b0);
    send_point(32'sd30, 32'sd8, 1'b1);
    send_point(32'sd10, 32'sd5, 1'b0);
    send_point(32'sd20, 32'sd6, 1'b0);
    send_point(32'sd5, 32'sd6, 1'b1);
  endtask

  // well-formed sets with random content, some broken ones
  task automatic test_random_sets();
    int unsigned sent, len, step_max, k;
    logic signed [31:0] x, y;
    sent = 0;
    while (sent < 220) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      step_max = ($urandom_range(0, 3) == 0) ? 32'h1FFF_FFFF : $urandom_range(1, 32'h3_0000);
      x = $urandom;
      if ($urandom_range(0, 1)) x = -$signed(32'($urandom_range(0, 32'h1000_0000)));
      rsp_stall_long = ($urandom_range(0, 7) == 0);
      for (k = 0; k < len; k++) begin
        y = ($urandom_range(0, 5) == 0) ? $urandom : $signed(32'($urandom_range(0, 32'h4_0000)))
            - 32'sh2_0000;
        send_point(x, y, k == len - 1);
        sent++;
        if ($urandom_range(0, 29) == 0) x = x - $signed(32'($urandom_range(0, 5)));
        else if (x > 32'sh7FFF_FFFF - $signed(step_max)) x = 32'sh7FFF_FFFF;
        else x = x + $signed(32'($urandom_range(1, step_max)));
      end
    end
    rsp_stall_long = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    req_if.valid = 1'b0;
    req_if.knot_x = '0;
    req_if.knot_y = '0;
    req_if.final_point = 1'b0;
    clear_set();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_short_sets();
    test_extremes();
    test_x_order();
    test_random_sets();
    req_if.valid <= 1'b0;
    waited = 0;
    while (deriv_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (400) @(posedge clk_i);
    if (fail_cnt == 0 && deriv_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (deriv_q.size() != 0) $error("%0d expected results never arrived", deriv_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
